// ===== hw/rtl/dbd_pkg.sv =====
// ----------------------------------------------------------------------------
// dbd_pkg - shared types and constants for the days-between-dates block
// Transaction payloads, calendar constants and the month tables.
// ----------------------------------------------------------------------------
`default_nettype none

package dbd_pkg;

    localparam int unsigned DAY_W    = 5;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned COUNT_W  = 22;
    localparam int unsigned STATUS_W = 2;

    // serial day number before truncation (invalid years may run past 22 bits)
    localparam int unsigned BASE_W   = 23;
    // day of year, 1..366
    localparam int unsigned DOY_W    = 9;
    // year / 100 fits in 8 bits for any 14-bit year
    localparam int unsigned QUOT_W   = 8;

    // y / 100 == (y * DIV100_MUL) >> DIV100_SHIFT, exact for y < 43690
    localparam int unsigned DIV100_MUL   = 10486;
    localparam int unsigned DIV100_SHIFT = 20;
    localparam int unsigned PROD_W       = 2 * YEAR_W;

    localparam int unsigned DAYS_PER_YEAR = 365;
    localparam int unsigned CENTURY       = 100;
    localparam int unsigned LEAP_FEB_LEN  = 29;
    localparam int unsigned YEAR_MIN      = 1;
    localparam int unsigned YEAR_MAX      = 9999;
    localparam int unsigned MONTH_MIN     = 1;
    localparam int unsigned MONTH_MAX     = 12;
    localparam logic [MONTH_W-1:0] FEB    = 4'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam int unsigned         ST_FIRST_BIT   = 0;
    localparam int unsigned         ST_SECOND_BIT  = 1;

    typedef struct packed {
        logic [DAY_W-1:0]   first_day;
        logic [MONTH_W-1:0] first_month;
        logic [YEAR_W-1:0]  first_year;
        logic [DAY_W-1:0]   second_day;
        logic [MONTH_W-1:0] second_month;
        logic [YEAR_W-1:0]  second_year;
    } t_req;

    typedef struct packed {
        logic [COUNT_W-1:0]  day_count;
        logic [STATUS_W-1:0] status;
    } t_rsp;

    // length of a month in a common year; zero for month codes with no meaning
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1:    len = 5'd31;
            4'd2:    len = 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // days in the months before month m of a common year
    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] cum;
        case (m)
            4'd1:    cum = 9'd0;
            4'd2:    cum = 9'd31;
            4'd3:    cum = 9'd59;
            4'd4:    cum = 9'd90;
            4'd5:    cum = 9'd120;
            4'd6:    cum = 9'd151;
            4'd7:    cum = 9'd181;
            4'd8:    cum = 9'd212;
            4'd9:    cum = 9'd243;
            4'd10:   cum = 9'd273;
            4'd11:   cum = 9'd304;
            4'd12:   cum = 9'd334;
            default: cum = 9'd0;
        endcase
        return cum;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/days_between_dates.sv =====
// ----------------------------------------------------------------------------
// days_between_dates - absolute day count between two Gregorian dates
//
// Usage: present a transaction on i_req and raise start; it is taken at any
// rising edge where start is high and busy is low. busy is never raised, so
// one transaction may be taken every clock cycle.
// Each date is checked (year 1..9999, month 1..12, day within the month,
// leap February 29 days). The result appears on o_rsp for exactly one cycle
// with o_done high, once the transaction has passed the pipeline: three
// stages form the serial day numbers (divide by 100, year base and day of
// year, sum), and a fourth takes the absolute difference and status.
// Status bit 0 flags an invalid first date, bit 1 an invalid second date;
// day_count is then zero. Throughput: one transaction per cycle.
// Reset (synchronous, active low) clears the valid pipeline, so no result
// emerges for transactions in flight. The receiver cannot stall; results
// are presented once and not held.
// ----------------------------------------------------------------------------
`default_nettype none

module days_between_dates (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    input  wire dbd_pkg::t_req   i_req,
    output logic                 busy,
    output logic                 o_done,
    output dbd_pkg::t_rsp        o_rsp
);

    localparam int unsigned SER_LAT = 3;

    logic [dbd_pkg::COUNT_W-1:0] first_serial;
    logic [dbd_pkg::COUNT_W-1:0] second_serial;
    logic                        first_ok;
    logic                        second_ok;

    logic [SER_LAT-1:0]          r_vld;
    logic                        r_done;
    dbd_pkg::t_rsp               r_rsp;
    dbd_pkg::t_rsp               n_rsp;

    assign busy = 1'b0;

    dbd_serial u_first (
        .i_clk    (i_clk),
        .i_day    (i_req.first_day),
        .i_month  (i_req.first_month),
        .i_year   (i_req.first_year),
        .o_serial (first_serial),
        .o_ok     (first_ok)
    );

    dbd_serial u_second (
        .i_clk    (i_clk),
        .i_day    (i_req.second_day),
        .i_month  (i_req.second_month),
        .i_year   (i_req.second_year),
        .o_serial (second_serial),
        .o_ok     (second_ok)
    );

    always_comb begin
        n_rsp        = '0;
        n_rsp.status[dbd_pkg::ST_FIRST_BIT]  = !first_ok;
        n_rsp.status[dbd_pkg::ST_SECOND_BIT] = !second_ok;
        if (n_rsp.status == dbd_pkg::ST_OK) begin
            n_rsp.day_count = (first_serial >= second_serial)
                            ? first_serial - second_serial
                            : second_serial - first_serial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[SER_LAT-2:0], start && !busy};
            r_done <= r_vld[SER_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

`default_nettype wire

// ===== hw/rtl/dbd_serial.sv =====
// ----------------------------------------------------------------------------
// dbd_serial - date check and serial day number
// Three register stages: divide by 100, year base and day of year, final sum.
// Serial day 1 is 0001-01-01. Runs every cycle, no stall.
// ----------------------------------------------------------------------------
`default_nettype none

module dbd_serial (
    input  wire                                  i_clk,
    input  wire logic [dbd_pkg::DAY_W-1:0]       i_day,
    input  wire logic [dbd_pkg::MONTH_W-1:0]     i_month,
    input  wire logic [dbd_pkg::YEAR_W-1:0]      i_year,
    output logic      [dbd_pkg::COUNT_W-1:0]     o_serial,
    output logic                                 o_ok
);

    // stage 1
    logic [dbd_pkg::DAY_W-1:0]   r1_day;
    logic [dbd_pkg::MONTH_W-1:0] r1_month;
    logic [dbd_pkg::YEAR_W-1:0]  r1_year;
    logic [dbd_pkg::YEAR_W-1:0]  r1_prev;
    logic [dbd_pkg::QUOT_W-1:0]  r1_qy;
    logic [dbd_pkg::QUOT_W-1:0]  r1_qp;

    logic [dbd_pkg::YEAR_W-1:0]  n1_prev;
    logic [dbd_pkg::PROD_W-1:0]  n1_prod_y;
    logic [dbd_pkg::PROD_W-1:0]  n1_prod_p;

    // stage 2
    logic [dbd_pkg::BASE_W-1:0]  r2_base;
    logic [dbd_pkg::DOY_W-1:0]   r2_doy;
    logic                        r2_ok;

    logic [dbd_pkg::YEAR_W-1:0]  n2_rem;
    logic                        n2_leap;
    logic [dbd_pkg::DAY_W-1:0]   n2_mlen;
    logic                        n2_ok;
    logic [dbd_pkg::BASE_W-1:0]  n2_base;
    logic [dbd_pkg::DOY_W-1:0]   n2_doy;

    // stage 3
    logic [dbd_pkg::COUNT_W-1:0] r3_serial;
    logic                        r3_ok;

    always_comb begin
        n1_prev   = i_year - dbd_pkg::YEAR_W'(1);
        n1_prod_y = dbd_pkg::PROD_W'(i_year)  * dbd_pkg::PROD_W'(dbd_pkg::DIV100_MUL);
        n1_prod_p = dbd_pkg::PROD_W'(n1_prev) * dbd_pkg::PROD_W'(dbd_pkg::DIV100_MUL);
    end

    always_ff @(posedge i_clk) begin
        r1_day   <= i_day;
        r1_month <= i_month;
        r1_year  <= i_year;
        r1_prev  <= n1_prev;
        r1_qy    <= n1_prod_y[dbd_pkg::DIV100_SHIFT +: dbd_pkg::QUOT_W];
        r1_qp    <= n1_prod_p[dbd_pkg::DIV100_SHIFT +: dbd_pkg::QUOT_W];
    end

    always_comb begin
        n2_rem  = r1_year - dbd_pkg::YEAR_W'(r1_qy) * dbd_pkg::YEAR_W'(dbd_pkg::CENTURY);
        // divisible by 4 and not by 100, or by 400 (century count divisible by 4)
        n2_leap = (n2_rem != '0) ? (r1_year[1:0] == 2'b00) : (r1_qy[1:0] == 2'b00);
        n2_mlen = (r1_month == dbd_pkg::FEB && n2_leap)
                ? dbd_pkg::DAY_W'(dbd_pkg::LEAP_FEB_LEN)
                : dbd_pkg::month_len(r1_month);
        n2_ok   = (r1_year  >= dbd_pkg::YEAR_W'(dbd_pkg::YEAR_MIN))
               && (r1_year  <= dbd_pkg::YEAR_W'(dbd_pkg::YEAR_MAX))
               && (r1_month >= dbd_pkg::MONTH_W'(dbd_pkg::MONTH_MIN))
               && (r1_month <= dbd_pkg::MONTH_W'(dbd_pkg::MONTH_MAX))
               && (r1_day != '0)
               && (r1_day <= n2_mlen);
        n2_base = dbd_pkg::BASE_W'(r1_prev) * dbd_pkg::BASE_W'(dbd_pkg::DAYS_PER_YEAR)
                + dbd_pkg::BASE_W'(r1_prev >> 2)
                - dbd_pkg::BASE_W'(r1_qp)
                + dbd_pkg::BASE_W'(r1_qp >> 2);
        n2_doy  = dbd_pkg::days_before(r1_month)
                + dbd_pkg::DOY_W'(n2_leap && (r1_month > dbd_pkg::FEB))
                + dbd_pkg::DOY_W'(r1_day);
    end

    always_ff @(posedge i_clk) begin
        r2_base <= n2_base;
        r2_doy  <= n2_doy;
        r2_ok   <= n2_ok;
    end

    always_ff @(posedge i_clk) begin
        r3_serial <= dbd_pkg::COUNT_W'(r2_base + dbd_pkg::BASE_W'(r2_doy));
        r3_ok     <= r2_ok;
    end

    assign o_serial = r3_serial;
    assign o_ok     = r3_ok;

endmodule

`default_nettype wire
